@@ rtl/zrhd_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// zrhd_pkg
// Types and constants for the zero-run halfword decoder: the parser phase
// encoding and the widths of its counters.
// ----------------------------------------------------------------------------
package zrhd_pkg;

  localparam int unsigned SizeW  = 24;  // declared output size, bytes
  localparam int unsigned CountW = 25;  // bytes produced, room for overshoot

  // Parser phase, one-hot.
  typedef enum logic [4:0] {
    PH_HEADER = 5'b00001,  // four header bytes
    PH_ZERO   = 5'b00010,  // zero-count byte of a group
    PH_COPY   = 5'b00100,  // copy-count byte of a group
    PH_LIT_A  = 5'b01000,  // first byte of a literal pair
    PH_LIT_B  = 5'b10000   // second byte of a literal pair
  } phase_t;

  // Header byte positions: type byte, then size low, middle, high.
  localparam logic [1:0] HDR_TYPE = 2'd0;
  localparam logic [1:0] HDR_LO   = 2'd1;
  localparam logic [1:0] HDR_MID  = 2'd2;
  localparam logic [1:0] HDR_HI   = 2'd3;

endpackage

@@ rtl/zero_run_halfword_decoder.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// zero_run_halfword_decoder
// Parses a zero-run compressed byte stream and emits halfword results.
// ----------------------------------------------------------------------------
// Takes one stream byte per cycle on the byte channel, unless byte_stall holds
// it, and gives at most one result beat per byte on the result channel, in
// the cycle after the byte is taken. The byte decode is a single pass of
// small counter and compare logic between the parser registers and the
// result register, so the sustained rate is one byte per clock while no stall
// holds the flow. The result register acts as the only buffer: a new byte is
// taken while the held result is being drained, and byte_stall rises only
// when a result is held and the consumer stalls it. A stream begins with a
// byte marked by stream_start; a four-byte header (ignored type byte, then a
// 24-bit little-endian size) precedes groups of a zero-count byte, a
// copy-count byte and that many literal pairs. A zero run gives one beat with
// zero bytes and its repeat count; a literal pair gives one beat with repeat
// 1. The size is checked only at group end, so output may overshoot it; an
// end marker has repeat 0. Bytes after the end are dropped until the next stream_start.
// ----------------------------------------------------------------------------
module zero_run_halfword_decoder (
  input  logic       clk,
  input  logic       rst,
  // byte channel
  input  logic       byte_valid,
  output logic       byte_stall,
  input  logic [7:0] data_byte,
  input  logic       stream_start,
  // result channel
  output logic       res_valid,
  input  logic       res_stall,
  output logic [7:0] first_byte,
  output logic [7:0] second_byte,
  output logic [7:0] repeat_res,
  output logic       stream_end
);

  // Parser state.
  zrhd_pkg::phase_t               phase;
  logic [1:0]                     header_index;
  logic [zrhd_pkg::SizeW-1:0]     declared_size;
  logic [zrhd_pkg::CountW-1:0]    bytes_produced;
  logic [7:0]                     pairs_left;
  logic [7:0]                     held_byte;
  logic                           finished;

  zrhd_pkg::phase_t               phase_next;
  logic [1:0]                     header_index_next;
  logic [zrhd_pkg::SizeW-1:0]     declared_size_next;
  logic [zrhd_pkg::CountW-1:0]    bytes_produced_next;
  logic [7:0]                     pairs_left_next;
  logic [7:0]                     held_byte_next;
  logic                           finished_next;

  // Result produced by the byte being taken.
  logic       emit;
  logic [7:0] emit_first;
  logic [7:0] emit_second;
  logic [7:0] emit_repeat;
  logic       emit_end;

  logic       accept;
  logic       size_reached;
  logic [zrhd_pkg::CountW-1:0] bp_pair;

  // Hold the byte side only while a result sits stalled in the register.
  assign byte_stall = res_valid & res_stall;
  assign accept     = byte_valid & ~byte_stall;

  always_comb begin
    phase_next          = phase;
    header_index_next   = header_index;
    declared_size_next  = declared_size;
    bytes_produced_next = bytes_produced;
    pairs_left_next     = pairs_left;
    held_byte_next      = held_byte;
    finished_next       = finished;
    emit                = 1'b0;
    emit_first          = 8'd0;
    emit_second         = 8'd0;
    emit_repeat         = 8'd0;
    emit_end            = 1'b0;
    bp_pair             = '0;
    size_reached        = 1'b0;

    if (accept) begin
      // A start restarts the parser, and the same byte is parsed after it.
      if (stream_start) begin
        phase_next          = zrhd_pkg::PH_HEADER;
        header_index_next   = zrhd_pkg::HDR_TYPE;
        declared_size_next  = '0;
        bytes_produced_next = '0;
        pairs_left_next     = 8'd0;
        held_byte_next      = 8'd0;
        finished_next       = 1'b0;
      end

      if (!finished_next) begin
        unique case (phase_next)
          zrhd_pkg::PH_HEADER: begin
            unique case (header_index_next)
              zrhd_pkg::HDR_TYPE: ;
              zrhd_pkg::HDR_LO:   declared_size_next[7:0]   = declared_size_next[7:0] | data_byte;
              zrhd_pkg::HDR_MID:  declared_size_next[15:8]  = declared_size_next[15:8] | data_byte;
              zrhd_pkg::HDR_HI:   declared_size_next[23:16] = declared_size_next[23:16] | data_byte;
              default: ;
            endcase
            if (header_index_next == zrhd_pkg::HDR_HI) begin
              header_index_next = zrhd_pkg::HDR_TYPE;
              if (declared_size_next == '0) begin
                // Empty stream: end marker straight away.
                finished_next = 1'b1;
                emit          = 1'b1;
                emit_end      = 1'b1;
              end else begin
                phase_next = zrhd_pkg::PH_ZERO;
              end
            end else begin
              header_index_next = header_index_next + 2'd1;
            end
          end

          zrhd_pkg::PH_ZERO: begin
            phase_next = zrhd_pkg::PH_COPY;
            if (data_byte != 8'd0) begin
              bytes_produced_next = bytes_produced_next
                                  + {{(zrhd_pkg::CountW-9){1'b0}}, data_byte, 1'b0};
              emit        = 1'b1;
              emit_repeat = data_byte;
            end
          end

          zrhd_pkg::PH_COPY: begin
            if (data_byte != 8'd0) begin
              pairs_left_next = data_byte;
              phase_next      = zrhd_pkg::PH_LIT_A;
            end else begin
              phase_next   = zrhd_pkg::PH_ZERO;
              size_reached = bytes_produced_next
                          >= {{(zrhd_pkg::CountW-zrhd_pkg::SizeW){1'b0}}, declared_size_next};
              if (size_reached) begin
                finished_next = 1'b1;
                emit          = 1'b1;
                emit_end      = 1'b1;
              end
            end
          end

          zrhd_pkg::PH_LIT_A: begin
            held_byte_next = data_byte;
            phase_next     = zrhd_pkg::PH_LIT_B;
          end

          zrhd_pkg::PH_LIT_B: begin
            bp_pair             = bytes_produced_next + zrhd_pkg::CountW'(2);
            bytes_produced_next = bp_pair;
            pairs_left_next     = pairs_left_next - 8'd1;
            emit                = 1'b1;
            emit_first          = held_byte_next;
            emit_second         = data_byte;
            emit_repeat         = 8'd1;
            if (pairs_left_next == 8'd0) begin
              phase_next   = zrhd_pkg::PH_ZERO;
              size_reached = bp_pair
                          >= {{(zrhd_pkg::CountW-zrhd_pkg::SizeW){1'b0}}, declared_size_next};
              if (size_reached) begin
                finished_next = 1'b1;
                emit_end      = 1'b1;
              end
            end else begin
              phase_next = zrhd_pkg::PH_LIT_A;
            end
          end

          default: ;
        endcase
      end
    end
  end

  // Parser registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= zrhd_pkg::PH_HEADER;
      header_index   <= zrhd_pkg::HDR_TYPE;
      declared_size  <= '0;
      bytes_produced <= '0;
      pairs_left     <= 8'd0;
      held_byte      <= 8'd0;
      finished       <= 1'b1;
    end else begin
      phase          <= phase_next;
      header_index   <= header_index_next;
      declared_size  <= declared_size_next;
      bytes_produced <= bytes_produced_next;
      pairs_left     <= pairs_left_next;
      held_byte      <= held_byte_next;
      finished       <= finished_next;
    end
  end

  // Result register: load on a producing byte, drop once the beat is taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (accept && emit) begin
      res_valid <= 1'b1;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && emit) begin
      first_byte  <= emit_first;
      second_byte <= emit_second;
      repeat_res  <= emit_repeat;
      stream_end  <= emit_end;
    end
  end

endmodule

@@ rtl/zrhd_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// zrhd_checker
// Port-level checks for the zero-run halfword decoder, bound to the top level.
// ----------------------------------------------------------------------------
module zrhd_checker (
  input logic       clk,
  input logic       rst,
  input logic       byte_stall,
  input logic       res_valid,
  input logic       res_stall,
  input logic [7:0] first_byte,
  input logic [7:0] second_byte,
  input logic [7:0] repeat_res,
  input logic       stream_end
);

  // No result beat right after reset.
  a_reset_empty: assert property (@(posedge clk) rst |=> !res_valid)
    else $error("result valid after reset");

  // A stalled result beat holds.
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_stall |=> res_valid && $stable(first_byte)
      && $stable(second_byte) && $stable(repeat_res) && $stable(stream_end))
    else $error("stalled result beat changed");

  // The byte side stalls only behind a stalled result.
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    byte_stall |-> res_valid && res_stall)
    else $error("byte stall without a stalled result");

  // An end marker is empty and closes the stream.
  a_end_marker: assert property (@(posedge clk) disable iff (rst)
    res_valid && repeat_res == 8'd0 |->
      stream_end && first_byte == 8'd0 && second_byte == 8'd0)
    else $error("malformed end marker");

  // A zero run never carries literal bytes or the end flag.
  a_zero_run: assert property (@(posedge clk) disable iff (rst)
    res_valid && repeat_res > 8'd1 |->
      !stream_end && first_byte == 8'd0 && second_byte == 8'd0)
    else $error("malformed zero run");

endmodule

bind zero_run_halfword_decoder zrhd_checker u_zrhd_checker (.*);

@@ test/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the zero-run halfword decoder.
// ----------------------------------------------------------------------------
// Feeds compressed byte streams through the byte channel and checks every
// result beat against a built-in model of the parser. A short table of
// directed bytes goes first. It covers bytes before any start, a zero declared
// size, the largest declared size, the largest zero run, an empty group, a
// restart in mid-stream and a literal group that ends the stream. Random
// streams follow. Most of them are well formed with random sizes, runs and
// literals. Some are cut short by a new start, and some carry trailing noise.
// Both sides idle in random bursts, and there is no idling in the closing part
// of the run.
// ----------------------------------------------------------------------------
module tb_top;

  // Result beat as the decoder presents it.
  typedef struct packed {
    logic [7:0] first;
    logic [7:0] second;
    logic [7:0] rep;
    logic       fin;
  } halfword_res_t;

  // One row of directed stimulus. When pinned is set, the expectation is the
  // one typed into the row. Otherwise the parser model supplies it.
  typedef struct packed {
    logic [7:0]    data;
    logic          start;
    logic          pinned;
    logic          has_res;
    halfword_res_t res;
  } byte_row_t;

  localparam halfword_res_t NO_RES   = '0;
  localparam halfword_res_t END_MARK = '{8'h00, 8'h00, 8'h00, 1'b1};
  localparam int unsigned   ITEM_TARGET  = 1600;
  localparam int unsigned   CALM_FROM    = 1400;  // no idling from here on
  localparam int unsigned   STALL_LIMIT  = 2000;  // cycles with no beat moving
  localparam int unsigned   N_DIRECTED   = 25;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       byte_valid = 1'b0;
  logic       byte_stall;
  logic [7:0] data_byte = 8'h00;
  logic       stream_start = 1'b0;
  logic       res_valid;
  logic       res_stall = 1'b0;
  logic [7:0] first_byte;
  logic [7:0] second_byte;
  logic [7:0] repeat_res;
  logic       stream_end;

  zero_run_halfword_decoder dut (
    .clk          (clk),
    .rst          (rst),
    .byte_valid   (byte_valid),
    .byte_stall   (byte_stall),
    .data_byte    (data_byte),
    .stream_start (stream_start),
    .res_valid    (res_valid),
    .res_stall    (res_stall),
    .first_byte   (first_byte),
    .second_byte  (second_byte),
    .repeat_res   (repeat_res),
    .stream_end   (stream_end)
  );

  always #6 clk = ~clk;

  // Parser model state, starting out idle until the first start.
  zrhd_pkg::phase_t pr_phase    = zrhd_pkg::PH_HEADER;
  logic [1:0]       pr_hdr_idx  = zrhd_pkg::HDR_TYPE;
  logic [23:0]      pr_size     = '0;
  logic [24:0]      pr_produced = '0;
  logic [7:0]       pr_pairs    = '0;
  logic [7:0]       pr_held     = '0;
  logic             pr_idle     = 1'b1;

  halfword_res_t expected_halfwords[$];

  int unsigned errors         = 0;
  int unsigned live_bytes     = 0;
  int unsigned ignored_bytes  = 0;
  int unsigned random_streams = 0;
  int unsigned zero_runs      = 0;
  int unsigned literal_pairs  = 0;
  int unsigned end_markers    = 0;
  bit          idle_mode      = 1'b1;  // random gaps and stalls allowed
  bit          calm           = 1'b0;  // closing part: no idling at all
  int          stall_left     = 0;

  // Directed bytes. A byte in the data column is read as a header byte, a zero
  // count, a copy count or a literal, depending on where it falls in a stream.
  byte_row_t directed_rows [N_DIRECTED] = '{
    // byte before any start: dropped
    '{8'hFF, 1'b0, 1'b1, 1'b0, NO_RES},
    // declared size zero: end marker on the last header byte
    '{8'h00, 1'b1, 1'b1, 1'b0, NO_RES},
    '{8'h00, 1'b0, 1'b1, 1'b0, NO_RES},
    '{8'h00, 1'b0, 1'b1, 1'b0, NO_RES},
    '{8'h00, 1'b0, 1'b1, 1'b1, END_MARK},
    // byte after the end: dropped
    '{8'h37, 1'b0, 1'b1, 1'b0, NO_RES},
    // largest declared size, one-halfword zero run, then a cut mid-pair
    '{8'hFF, 1'b1, 1'b1, 1'b0, NO_RES},
    '{8'hFF, 1'b0, 1'b1, 1'b0, NO_RES},
    '{8'hFF, 1'b0, 1'b1, 1'b0, NO_RES},
    '{8'hFF, 1'b0, 1'b1, 1'b0, NO_RES},
    '{8'h01, 1'b0, 1'b1, 1'b1, '{8'h00, 8'h00, 8'h01, 1'b0}},
    '{8'h01, 1'b0, 1'b0, 1'b0, NO_RES},
    '{8'h80, 1'b0, 1'b0, 1'b0, NO_RES},
    // restart where the second literal byte was due; size 4
    '{8'h5A, 1'b1, 1'b1, 1'b0, NO_RES},
    '{8'h04, 1'b0, 1'b1, 1'b0, NO_RES},
    '{8'h00, 1'b0, 1'b1, 1'b0, NO_RES},
    '{8'h00, 1'b0, 1'b1, 1'b0, NO_RES},
    // empty group
    '{8'h00, 1'b0, 1'b0, 1'b0, NO_RES},
    '{8'h00, 1'b0, 1'b0, 1'b0, NO_RES},
    // largest zero run, then two literal pairs; the last one ends the stream
    '{8'hFF, 1'b0, 1'b1, 1'b1, '{8'h00, 8'h00, 8'hFF, 1'b0}},
    '{8'h02, 1'b0, 1'b0, 1'b0, NO_RES},
    '{8'hFF, 1'b0, 1'b0, 1'b0, NO_RES},
    '{8'h00, 1'b0, 1'b0, 1'b0, NO_RES},
    '{8'h00, 1'b0, 1'b0, 1'b0, NO_RES},
    '{8'hFF, 1'b0, 1'b0, 1'b0, NO_RES}
  };

  // Advance the parser model by one byte; return 1 when the byte yields a
  // result beat, which is then in r.
  function automatic bit decode_byte(input logic [7:0] b, input logic s,
                                     output halfword_res_t r);
    r = NO_RES;
    if (s) begin
      pr_phase    = zrhd_pkg::PH_HEADER;
      pr_hdr_idx  = zrhd_pkg::HDR_TYPE;
      pr_size     = '0;
      pr_produced = '0;
      pr_pairs    = '0;
      pr_held     = '0;
      pr_idle     = 1'b0;
    end
    if (pr_idle) return 1'b0;
    case (pr_phase)
      zrhd_pkg::PH_HEADER: begin
        // The type byte is skipped; the size comes low byte first.
        case (pr_hdr_idx)
          zrhd_pkg::HDR_LO:  pr_size[7:0]   = b;
          zrhd_pkg::HDR_MID: pr_size[15:8]  = b;
          zrhd_pkg::HDR_HI:  pr_size[23:16] = b;
          default: ;
        endcase
        if (pr_hdr_idx == zrhd_pkg::HDR_HI) begin
          pr_hdr_idx = zrhd_pkg::HDR_TYPE;
          if (pr_size == '0) begin
            pr_idle = 1'b1;
            r = END_MARK;
            return 1'b1;
          end
          pr_phase = zrhd_pkg::PH_ZERO;
        end else begin
          pr_hdr_idx = pr_hdr_idx + 2'd1;
        end
        return 1'b0;
      end
      zrhd_pkg::PH_ZERO: begin
        pr_phase = zrhd_pkg::PH_COPY;
        if (b != 8'h00) begin
          pr_produced = pr_produced + {16'b0, b, 1'b0};
          r = '{8'h00, 8'h00, b, 1'b0};
          return 1'b1;
        end
        return 1'b0;
      end
      zrhd_pkg::PH_COPY: begin
        if (b != 8'h00) begin
          pr_pairs = b;
          pr_phase = zrhd_pkg::PH_LIT_A;
          return 1'b0;
        end
        // Check the size only at group end.
        pr_phase = zrhd_pkg::PH_ZERO;
        if (pr_produced >= {1'b0, pr_size}) begin
          pr_idle = 1'b1;
          r = END_MARK;
          return 1'b1;
        end
        return 1'b0;
      end
      zrhd_pkg::PH_LIT_A: begin
        pr_held  = b;
        pr_phase = zrhd_pkg::PH_LIT_B;
        return 1'b0;
      end
      default: begin
        pr_produced = pr_produced + 25'd2;
        pr_pairs    = pr_pairs - 8'd1;
        r = '{pr_held, b, 8'h01, 1'b0};
        if (pr_pairs == 8'h00) begin
          pr_phase = zrhd_pkg::PH_ZERO;
          if (pr_produced >= {1'b0, pr_size}) begin
            pr_idle = 1'b1;
            r.fin   = 1'b1;
          end
        end else begin
          pr_phase = zrhd_pkg::PH_LIT_A;
        end
        return 1'b1;
      end
    endcase
  endfunction

  // Drive one byte beat from a falling edge, hold it until it is taken, and
  // queue what it should produce. Return at the next falling edge with valid
  // still high, so that the next call either drives a new byte or drops valid
  // for a gap.
  task automatic push_byte(input logic [7:0] d, input logic s, input bit pinned,
                           input bit pinned_has, input halfword_res_t pinned_res);
    halfword_res_t got;
    bit            has;
    int            gap;
    gap = 0;
    if (idle_mode && !calm && $urandom_range(0, 7) == 0) gap = $urandom_range(1, 16);
    if (gap > 0) begin
      byte_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    byte_valid   <= 1'b1;
    data_byte    <= d;
    stream_start <= s;
    do @(posedge clk); while (byte_stall);
    if (!s && pr_idle) ignored_bytes++;
    else live_bytes++;
    has = decode_byte(d, s, got);
    if (pinned) begin
      has = pinned_has;
      got = pinned_res;
    end
    if (has) expected_halfwords = {expected_halfwords, got};
    @(negedge clk);
  endtask

  task automatic push_random(input logic [7:0] d, input logic s);
    push_byte(d, s, 1'b0, 1'b0, NO_RES);
  endtask

  // Send one random stream: header, then groups until the declared size is
  // reached or the stream is cut short. Trailing bytes afterwards are either
  // dropped noise or, after a cut, stray bytes the parser still takes.
  task automatic send_stream();
    logic [23:0] size;
    int          cut_at;
    int          sent;
    int          zc;
    int          cc;
    int          noise;
    idle_mode = ($urandom_range(0, 3) != 0);
    case ($urandom_range(0, 9))
      0:             size = '0;
      1, 2, 3, 4, 5: size = 24'($urandom_range(1, 64));
      6, 7, 8:       size = 24'($urandom_range(65, 1500));
      default:       size = 24'($urandom());
    endcase
    // Cut some streams short; the huge sizes would never end otherwise.
    cut_at = ($urandom_range(0, 6) == 0) ? $urandom_range(1, 40) : 400;
    push_random(8'($urandom()), 1'b1);
    push_random(size[7:0], 1'b0);
    push_random(size[15:8], 1'b0);
    push_random(size[23:16], 1'b0);
    sent = 4;
    while (!pr_idle && sent < cut_at) begin
      case ($urandom_range(0, 19))
        0, 1, 2, 3, 4, 5, 6:    zc = 0;
        7, 8, 9, 10, 11, 12, 13: zc = $urandom_range(1, 8);
        14, 15, 16, 17:          zc = $urandom_range(9, 254);
        default:                 zc = 255;
      endcase
      push_random(8'(zc), 1'b0);
      sent++;
      if (pr_idle || sent >= cut_at) break;
      case ($urandom_range(0, 19))
        0, 1, 2, 3, 4, 5:    cc = 0;
        6, 7, 8, 9, 10, 11, 12, 13, 14, 15: cc = $urandom_range(1, 4);
        16, 17, 18:          cc = $urandom_range(5, 32);
        default:             cc = $urandom_range(33, 255);
      endcase
      push_random(8'(cc), 1'b0);
      sent++;
      for (int p = 0; p < 2 * cc && sent < cut_at; p++) begin
        push_random(8'($urandom()), 1'b0);
        sent++;
      end
    end
    noise = $urandom_range(0, 2);
    repeat (noise) push_random(8'($urandom()), 1'b0);
  endtask

  // Result side stall: random bursts, always followed by an open cycle so that
  // a beat can drain.
  always @(negedge clk) begin
    if (calm || !idle_mode) begin
      res_stall  <= 1'b0;
      stall_left = 0;
    end else if (stall_left > 0) begin
      res_stall  <= 1'b1;
      stall_left = stall_left - 1;
    end else if (res_stall) begin
      res_stall <= 1'b0;
    end else if ($urandom_range(0, 7) == 0) begin
      res_stall  <= 1'b1;
      stall_left = $urandom_range(1, 16) - 1;
    end else begin
      res_stall <= 1'b0;
    end
  end

  // Check each accepted result beat against the oldest expectation.
  always @(posedge clk) begin : result_check
    halfword_res_t want;
    if (!rst && res_valid && !res_stall) begin
      if (expected_halfwords.size() == 0) begin
        $error({"unexpected result beat: first_byte=%0h second_byte=%0h",
                " repeat_res=%0d stream_end=%0b"},
               first_byte, second_byte, repeat_res, stream_end);
        errors++;
      end else begin
        want = expected_halfwords.pop_front();
        if (first_byte !== want.first) begin
          $error("first_byte: expected %0h, got %0h", want.first, first_byte);
          errors++;
        end
        if (second_byte !== want.second) begin
          $error("second_byte: expected %0h, got %0h", want.second, second_byte);
          errors++;
        end
        if (repeat_res !== want.rep) begin
          $error("repeat_res: expected %0d, got %0d", want.rep, repeat_res);
          errors++;
        end
        if (stream_end !== want.fin) begin
          $error("stream_end: expected %0b, got %0b", want.fin, stream_end);
          errors++;
        end
        if (want.rep == 8'h00) end_markers++;
        else if (want.first == 8'h00 && want.second == 8'h00 && want.rep != 8'h01) zero_runs++;
        else if (want.rep == 8'h01) literal_pairs++;
        else zero_runs++;
      end
    end
  end

  // Watchdog: end the run when no beat moves on either channel for too long.
  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if ((byte_valid && !byte_stall) || (res_valid && !res_stall)) quiet = 0;
      else quiet++;
    end
    $display("Timeout: no beat moved for %0d cycles, %0d results outstanding",
             STALL_LIMIT, expected_halfwords.size());
    $display("Simulation FAILED");
    $finish;
  end

  initial begin : stimulus
    // Hold reset, then release it at a falling edge.
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (directed_rows[i]) begin
      push_byte(directed_rows[i].data, directed_rows[i].start, directed_rows[i].pinned,
                directed_rows[i].has_res, directed_rows[i].res);
    end

    while (live_bytes < ITEM_TARGET) begin
      if (live_bytes >= CALM_FROM) calm = 1'b1;
      send_stream();
      random_streams++;
    end
    byte_valid <= 1'b0;

    // Drain what is still in flight, then give the pipe spare cycles.
    while (expected_halfwords.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("Ran %0d parsed bytes (%0d dropped) over %0d random streams after the table",
             live_bytes, ignored_bytes, random_streams);
    $display("Checked %0d zero runs, %0d literal pairs, %0d end markers; %0d mismatches",
             zero_runs, literal_pairs, end_markers, errors);
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

@@ zero_run_halfword_decoder.f @@
rtl/zrhd_pkg.sv
rtl/zero_run_halfword_decoder.sv
rtl/zrhd_checker.sv
test/tb_top.sv
